// ===== design/lir_pkg.sv =====
// lir_pkg: types, constants and state encoding for the linear interpolation resampler
// no dependencies; imported by lir_front, lir_back and the top level
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int RATIO_BITS  = FRAC_BITS + 5;
    localparam int SLACK_BITS  = RATIO_BITS + 2;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE   = RATIO_BITS'(1) << FRAC_BITS;
    localparam logic [RATIO_BITS-1:0] RATIO_MIN   = RATIO_BITS'(1) << (FRAC_BITS - 4);
    localparam logic [RATIO_BITS-1:0] RATIO_MAX   = RATIO_BITS'(1) << (FRAC_BITS + 4);
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_ONE;

    localparam logic signed [SLACK_BITS-1:0] SLACK_ONE = SLACK_BITS'(1) << FRAC_BITS;
    localparam logic signed [SLACK_BITS-1:0] SLACK_TWO = SLACK_BITS'(2) << FRAC_BITS;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          final_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          run_last;
    } result_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fin;
        logic                          first;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOP,
        ST_FIN,
        ST_FLUSH,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/lir_fifo.sv =====
// lir_fifo: small register-based queue with fall-through read
// no package dependency; used for the command queue and the result queue
`default_nettype none

module lir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/lir_front.sv =====
// lir_front: accepts source samples and tags each with its place in the stream
// depends on lir_pkg; feeds the command queue
`default_nettype none

module lir_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lir_pkg::in_item_t item,
    output logic                   full,
    output logic                   q_push,
    output lir_pkg::cmd_t          q_cmd,
    input  wire logic              q_full
);

    import lir_pkg::*;

    logic have_prev_reg;
    logic have_prev_next;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    always_comb
    begin
        q_cmd.sample = item.sample_in;
        q_cmd.fin    = item.final_sample;
        q_cmd.first  = !have_prev_reg;
    end

    always_comb
    begin
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            have_prev_next = !item.final_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lir_back.sv =====
// lir_back: walks output positions, one interpolation per cycle unless the result queue stalls
// depends on lir_pkg; reads the command queue, writes the result queue, holds the ratio register
`default_nettype none

module lir_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           ratio_we,
    input  wire logic [lir_pkg::RATIO_BITS-1:0] ratio,
    input  wire logic                           cmd_empty,
    input  wire lir_pkg::cmd_t                  cmd,
    output logic                                cmd_pop,
    input  wire logic                           out_full,
    output logic                                out_push,
    output lir_pkg::result_t                    out_res
);

    import lir_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    back_state_t state_reg;
    back_state_t state_next;

    logic [RATIO_BITS-1:0]         ratio_reg;
    logic [RATIO_BITS-1:0]         ratio_eff;
    cmd_t                          cmd_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] prev_next;
    logic [RATIO_BITS-1:0]         phase_reg;
    logic [RATIO_BITS-1:0]         phase_next;
    logic                          first_open_reg;
    logic                          first_open_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic                          pend_first_reg;
    logic                          pend_first_next;
    logic signed [SAMPLE_BITS-1:0] pend_val_reg;
    logic signed [SAMPLE_BITS-1:0] pend_val_next;
    logic signed [SLACK_BITS-1:0]  pend_slack_reg;
    logic signed [SLACK_BITS-1:0]  pend_slack_next;
    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    logic signed [SAMPLE_BITS-1:0] stage_val_reg;
    logic signed [SAMPLE_BITS-1:0] stage_val_next;

    logic [RATIO_BITS-1:0]         phase_plus;
    logic signed [SLACK_BITS-1:0]  slack_new;
    logic signed [SLACK_BITS-1:0]  slack_dec;
    logic                          slack_new_le0;
    logic                          slack_dec_le0;
    logic                          loop_go;
    logic                          flush_go;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_sh;
    logic signed [SAMPLE_BITS-1:0] lerp_val;
    logic                          emit_req;
    logic signed [SAMPLE_BITS-1:0] emit_val;
    logic                          advance;

    // clamped step and position arithmetic
    always_comb
    begin
        if (ratio_reg < RATIO_MIN)
        begin
            ratio_eff = RATIO_MIN;
        end
        else if (ratio_reg > RATIO_MAX)
        begin
            ratio_eff = RATIO_MAX;
        end
        else
        begin
            ratio_eff = ratio_reg;
        end
        phase_plus    = phase_reg + ratio_eff;
        slack_new     = signed'({2'b00, phase_plus}) - SLACK_TWO;
        slack_dec     = pend_slack_reg - SLACK_ONE;
        slack_new_le0 = slack_new[SLACK_BITS-1] || (slack_new == '0);
        slack_dec_le0 = slack_dec[SLACK_BITS-1] || (slack_dec == '0);
        loop_go       = (phase_reg[RATIO_BITS-1:FRAC_BITS] == '0);
        flush_go      = loop_go && ((phase_plus <= RATIO_ONE) || first_open_reg);
    end

    // interpolation: prev + floor((cur - prev) * frac)
    always_comb
    begin
        diff     = signed'({cmd_reg.sample[SAMPLE_BITS-1], cmd_reg.sample})
                 - signed'({prev_reg[SAMPLE_BITS-1], prev_reg});
        prod     = diff * signed'({1'b0, phase_reg[FRAC_BITS-1:0]});
        prod_sh  = prod >>> FRAC_BITS;
        lerp_val = prev_reg + SAMPLE_BITS'(prod_sh);
    end

    // emission request per state and stall decision
    always_comb
    begin
        emit_req = 1'b0;
        emit_val = prev_reg;
        unique case (state_reg)
            ST_START:
            begin
                emit_req = !cmd_reg.first && pend_valid_reg && slack_dec_le0;
                emit_val = pend_val_reg;
            end
            ST_LOOP:
            begin
                emit_req = loop_go && !pend_valid_reg && slack_new_le0;
                emit_val = lerp_val;
            end
            ST_FIN:
            begin
                emit_req = cmd_reg.fin && pend_valid_reg && pend_first_reg;
                emit_val = pend_val_reg;
            end
            ST_FLUSH:
            begin
                emit_req = flush_go;
                emit_val = prev_reg;
            end
            default:
            begin
                emit_req = 1'b0;
                emit_val = prev_reg;
            end
        endcase
        if (state_reg == ST_DONE)
        begin
            advance = !stage_valid_reg || !out_full;
        end
        else
        begin
            advance = !emit_req || !stage_valid_reg || !out_full;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (advance)
                begin
                    state_next = cmd_reg.first ? ST_FIN : ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (advance && !loop_go)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (advance)
                begin
                    state_next = cmd_reg.fin ? ST_FLUSH : ST_DONE;
                end
            end
            ST_FLUSH:
            begin
                if (advance && !flush_go)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates and outputs
    always_comb
    begin
        prev_next        = prev_reg;
        phase_next       = phase_reg;
        first_open_next  = first_open_reg;
        pend_valid_next  = pend_valid_reg;
        pend_first_next  = pend_first_reg;
        pend_val_next    = pend_val_reg;
        pend_slack_next  = pend_slack_reg;
        stage_valid_next = stage_valid_reg;
        stage_val_next   = stage_val_reg;
        cmd_pop          = 1'b0;
        out_push         = 1'b0;
        out_res.sample_out = stage_val_reg;
        out_res.run_last   = (state_reg == ST_DONE);

        if (state_reg != ST_DONE)
        begin
            out_push = emit_req && stage_valid_reg && !out_full;
        end
        else
        begin
            out_push = stage_valid_reg && !out_full;
        end

        if (emit_req && advance)
        begin
            stage_valid_next = 1'b1;
            stage_val_next   = emit_val;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop = !cmd_empty;
            end
            ST_START:
            begin
                if (advance)
                begin
                    if (cmd_reg.first)
                    begin
                        prev_next  = cmd_reg.sample;
                        phase_next = '0;
                    end
                    else if (pend_valid_reg)
                    begin
                        pend_slack_next = slack_dec;
                        if (slack_dec_le0)
                        begin
                            pend_valid_next = 1'b0;
                        end
                    end
                end
            end
            ST_LOOP:
            begin
                if (advance)
                begin
                    if (loop_go)
                    begin
                        first_open_next = 1'b0;
                        phase_next      = phase_plus;
                        if (!pend_valid_reg && !slack_new_le0)
                        begin
                            pend_valid_next = 1'b1;
                            pend_val_next   = lerp_val;
                            pend_slack_next = slack_new;
                            pend_first_next = first_open_reg;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg - RATIO_ONE;
                        prev_next  = cmd_reg.sample;
                    end
                end
            end
            ST_FIN:
            begin
                if (advance && cmd_reg.fin)
                begin
                    pend_valid_next = 1'b0;
                end
            end
            ST_FLUSH:
            begin
                if (advance)
                begin
                    if (flush_go)
                    begin
                        first_open_next = 1'b0;
                        phase_next      = phase_plus;
                    end
                    else
                    begin
                        prev_next       = '0;
                        phase_next      = '0;
                        pend_valid_next = 1'b0;
                        pend_first_next = 1'b0;
                        first_open_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (advance)
                begin
                    stage_valid_next = 1'b0;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ratio_reg       <= RATIO_RESET;
            prev_reg        <= '0;
            phase_reg       <= '0;
            first_open_reg  <= 1'b1;
            pend_valid_reg  <= 1'b0;
            pend_first_reg  <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_reg        <= prev_next;
            phase_reg       <= phase_next;
            first_open_reg  <= first_open_next;
            pend_valid_reg  <= pend_valid_next;
            pend_first_reg  <= pend_first_next;
            stage_valid_reg <= stage_valid_next;
            if (ratio_we)
            begin
                ratio_reg <= ratio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg   <= pend_val_next;
        pend_slack_reg <= pend_slack_next;
        stage_val_reg  <= stage_val_next;
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_pend_not_first_open: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !first_open_reg)
        else $error("deferred result held while position zero is still open");

    a_idle_stage_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !stage_valid_reg)
        else $error("staged result left over between transactions");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_START))
        else $error("command popped without starting its sequence");

endmodule

`default_nettype wire

// ===== design/linear_interp_resampler_core.sv =====
// linear_interp_resampler_core: top level of the linear interpolation resampler
// depends on lir_pkg, lir_front, lir_fifo and lir_back
//
//   channel   handshake           payload
//   input     push / full         item   (sample_in, final_sample)
//   result    pop / empty         result (sample_out, run_last)
//   config    ratio_we            ratio  (step_ratio, unsigned Q5.16)
//
// the back sequencer walks m output positions per sample, m up to 16, one interpolation
// a cycle while the result queue has room; a final sample then holds its value flat for up
// to 16 more positions, and the first sample of a stream skips the walk
// reset clears the queues and stream state and loads a step of 1.0
// the command queue lets input keep arriving while the sequencer works
// a full result queue stalls the sequencer at its next result

`default_nettype none

module linear_interp_resampler_core #(
    parameter int CMD_DEPTH = lir_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = lir_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire lir_pkg::in_item_t              item,
    output logic                                full,
    input  wire logic                           pop,
    output lir_pkg::result_t                    result,
    output logic                                empty,
    input  wire logic                           ratio_we,
    input  wire logic [lir_pkg::RATIO_BITS-1:0] ratio
);

    import lir_pkg::*;

    logic                     cq_push;
    cmd_t                     cq_wcmd;
    logic                     cq_full;
    logic                     cq_pop;
    logic [$bits(cmd_t)-1:0]  cq_rdata;
    logic                     cq_empty;
    cmd_t                     cq_rcmd;
    logic                     rq_push;
    result_t                  rq_wres;
    logic                     rq_full;
    logic [$bits(result_t)-1:0] rq_rdata;

    assign cq_rcmd = cmd_t'(cq_rdata);
    assign result  = result_t'(rq_rdata);

    lir_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_push (cq_push),
        .q_cmd  (cq_wcmd),
        .q_full (cq_full)
    );

    lir_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wcmd),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    lir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ratio_we  (ratio_we),
        .ratio     (ratio),
        .cmd_empty (cq_empty),
        .cmd       (cq_rcmd),
        .cmd_pop   (cq_pop),
        .out_full  (rq_full),
        .out_push  (rq_push),
        .out_res   (rq_wres)
    );

    lir_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wres),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

endmodule

`default_nettype wire
